// File: sv/cpf_pkg.sv
package cpf_pkg;

    // Default depth of the point store.
    localparam int MAX_POINTS_DEF = 16;

    // Field widths.
    localparam int POS_W  = 24;
    localparam int ZOOM_W = 16;
    localparam int ZONE_W = 23;
    localparam int CFG_W  = 23;
    localparam int CFG_IDX_W = 3;

    // A segment length is below 2^27 Q.8 units.
    localparam int LEN_W = 27;

    // Reset values of the configuration registers and of the view.
    localparam logic [ZONE_W-1:0] HDZ_RESET   = 23'd25600;
    localparam logic [ZONE_W-1:0] VDZ_RESET   = 23'd38400;
    localparam logic [15:0]       SPEED_RESET = 16'd50;
    localparam logic [9:0]        ZW_RESET    = 10'd100;
    localparam logic [ZOOM_W-1:0] ZOOM_ONE    = 16'd256;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_BEGIN  = 3'd1,
        ACT_APPEND = 3'd2,
        ACT_START  = 3'd3,
        ACT_MODE   = 3'd4,
        ACT_VIEW   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        MODE_INACTIVE = 2'd0,
        MODE_TARGET   = 2'd1,
        MODE_PATH     = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_HDZ   = 2'd0,
        CFG_VDZ   = 2'd1,
        CFG_SPEED = 2'd2,
        CFG_ZW    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_ZOOM = 2'd2
    } axis_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SEG,
        ST_MUL,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_CMP,
        ST_LAST,
        ST_IMUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    // One stored path point.
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [ZOOM_W-1:0]       zoom;
        logic signed [POS_W-1:0] rot;
    } point_t;

endpackage

// File: sv/camera_path_follower.sv
// Simple actions, follow-target and empty-path ticks go from acceptance straight to the output
// state; a one-point path first reads its point; otherwise each segment walked is read and
// measured by the square root, plus one divider pass per axis when the view lands in a segment.
// Throughput: one word at a time; the next word can be accepted in the cycle in which m_valid rises,
// and a finished word waits in the output state while the previous one is not yet taken.
// Reset (synchronous, aresetn low) restores the configuration registers, mode follow target, view at
// the origin with zoom one and an empty path; the point memory itself is not cleared.
module camera_path_follower #(
    parameter int MAX_POINTS = cpf_pkg::MAX_POINTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cpf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cpf_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_action,
    input  logic signed [cpf_pkg::POS_W-1:0]  s_point_x,
    input  logic signed [cpf_pkg::POS_W-1:0]  s_point_y,
    input  logic [cpf_pkg::ZOOM_W-1:0]        s_point_zoom,
    input  logic signed [cpf_pkg::POS_W-1:0]  s_point_rotation,
    input  logic [15:0]                       s_tick_time,
    input  logic                              s_continue_flag,
    input  logic [1:0]                        s_new_mode,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [cpf_pkg::POS_W-1:0]  m_view_x,
    output logic signed [cpf_pkg::POS_W-1:0]  m_view_y,
    output logic [cpf_pkg::ZOOM_W-1:0]        m_view_zoom,
    output logic [1:0]                        m_current_mode,
    output logic                              m_path_done,
    output logic [1:0]                        m_status
);

    import cpf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = LEN_W + ADDR_W + 1;
    localparam int CMP_W  = ((SUM_W > 32) ? SUM_W : 32) + 1;
    localparam int SQ_W   = 2 * POS_W + 2;
    localparam int PROD_W = POS_W + LEN_W;

    // Registers.
    state_t                   state_reg, state_next;
    mode_t                    mode_reg, mode_next;
    logic signed [POS_W-1:0]  view_x_reg, view_x_next;
    logic signed [POS_W-1:0]  view_y_reg, view_y_next;
    logic [ZOOM_W-1:0]        view_zoom_reg, view_zoom_next;
    logic [31:0]              travelled_reg, travelled_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ZONE_W-1:0]        hdz_reg, hdz_next;
    logic [ZONE_W-1:0]        vdz_reg, vdz_next;
    logic [15:0]              speed_reg, speed_next;
    logic [9:0]               zw_reg, zw_next;
    logic                     done_reg, done_next;
    status_t                  status_reg, status_next;
    logic [ADDR_W-1:0]        seg_reg, seg_next;
    logic [SUM_W-1:0]         so_far_reg, so_far_next;
    point_t                   pa_reg, pa_next;
    point_t                   pb_reg, pb_next;
    logic [2*POS_W-1:0]       dxsq_reg, dxsq_next;
    logic [2*POS_W-1:0]       dysq_reg, dysq_next;
    logic [25:0]              zwdz_reg, zwdz_next;
    logic [POS_W-1:0]         drot_reg, drot_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [LEN_W-1:0]         rem_reg, rem_next;
    axis_t                    axis_reg, axis_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [POS_W-1:0]  m_x_reg, m_x_next;
    logic signed [POS_W-1:0]  m_y_reg, m_y_next;
    logic [ZOOM_W-1:0]        m_zoom_reg, m_zoom_next;
    mode_t                    m_mode_reg, m_mode_next;
    logic                     m_done_reg, m_done_next;
    status_t                  m_status_reg, m_status_next;

    // Memory and arithmetic unit controls.
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    point_t                   ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    point_t                   ram_rdata;
    logic                     sqrt_start;
    logic                     sqrt_done;
    logic [SQ_W/2-1:0]        sqrt_root;
    logic                     div_start;
    logic                     div_done;
    logic [PROD_W-1:0]        div_quot;

    // Helper values.
    logic [31:0]              tick_prod;
    logic [32:0]              trav_sum;
    logic [CMP_W-1:0]         cmp_sum;
    logic signed [POS_W:0]    ax_a, ax_b, ax_diff, ax_q, ax_new;
    logic [POS_W-1:0]         ax_mag;

    function automatic logic [POS_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                   input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        abs_diff = d[POS_W] ? POS_W'(-d) : POS_W'(d);
    endfunction

    function automatic logic signed [POS_W-1:0] follow_axis(
        input logic signed [POS_W-1:0] view,
        input logic signed [POS_W-1:0] target,
        input logic [ZONE_W-1:0]       zone
    );
        logic signed [POS_W+1:0] d, z, t;
        d = (POS_W+2)'(target) - (POS_W+2)'(view);
        z = (POS_W+2)'(zone);
        t = (POS_W+2)'(target);
        if (d > z) begin
            t = t - z;
        end else if (d < -z) begin
            t = t + z;
        end else begin
            t = (POS_W+2)'(view);
        end
        if (t > (POS_W+2)'(8388607)) begin
            follow_axis = POS_W'(8388607);
        end else if (t < -(POS_W+2)'(8388608)) begin
            follow_axis = POS_W'(-(POS_W+2)'(8388608));
        end else begin
            follow_axis = POS_W'(t);
        end
    endfunction

    // Point memory: x, y, zoom and rotation in one word per entry.
    cpf_ram #(
        .WIDTH ($bits(point_t)),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Euclidean part of a segment length.
    cpf_isqrt #(
        .W (SQ_W)
    ) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   (SQ_W'(dxsq_reg) + SQ_W'(dysq_reg)),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // Interpolation divider, shared by the three axes.
    cpf_div #(
        .NW (PROD_W),
        .DW (LEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (prod_reg),
        .den     (len_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign tick_prod = 32'(s_tick_time) * 32'(speed_reg);
    assign trav_sum  = {1'b0, travelled_reg} + 33'(tick_prod[31:8]);
    assign cmp_sum   = CMP_W'(so_far_reg) + CMP_W'(len_reg);

    // Endpoints of the axis being interpolated.
    always_comb begin
        unique case (axis_reg)
            AXIS_X: begin
                ax_a = (POS_W+1)'(pa_reg.x);
                ax_b = (POS_W+1)'(pb_reg.x);
            end
            AXIS_Y: begin
                ax_a = (POS_W+1)'(pa_reg.y);
                ax_b = (POS_W+1)'(pb_reg.y);
            end
            default: begin
                ax_a = (POS_W+1)'({1'b0, pa_reg.zoom});
                ax_b = (POS_W+1)'({1'b0, pb_reg.zoom});
            end
        endcase
        ax_diff = ax_b - ax_a;
        ax_mag  = ax_diff[POS_W] ? POS_W'(-ax_diff) : POS_W'(ax_diff);
        ax_q    = neg_reg ? -(POS_W+1)'(div_quot[POS_W-1:0])
                          : (POS_W+1)'(div_quot[POS_W-1:0]);
        ax_new  = ax_a + ax_q;
    end

    // Sequencer: next state, register updates and memory accesses.
    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        view_x_next    = view_x_reg;
        view_y_next    = view_y_reg;
        view_zoom_next = view_zoom_reg;
        travelled_next = travelled_reg;
        count_next     = count_reg;
        hdz_next       = hdz_reg;
        vdz_next       = vdz_reg;
        speed_next     = speed_reg;
        zw_next        = zw_reg;
        done_next      = done_reg;
        status_next    = status_reg;
        seg_next       = seg_reg;
        so_far_next    = so_far_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        dxsq_next      = dxsq_reg;
        dysq_next      = dysq_reg;
        zwdz_next      = zwdz_reg;
        drot_next      = drot_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        axis_next      = axis_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        m_valid_next   = m_valid_reg;
        m_x_next       = m_x_reg;
        m_y_next       = m_y_reg;
        m_zoom_next    = m_zoom_reg;
        m_mode_next    = m_mode_reg;
        m_done_next    = m_done_reg;
        m_status_next  = m_status_reg;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'(count_reg);
        ram_wdata      = '{x: s_point_x, y: s_point_y, zoom: s_point_zoom,
                           rot: s_point_rotation};
        ram_raddr      = '0;
        sqrt_start     = 1'b0;
        div_start      = 1'b0;
        s_ready        = (state_reg == ST_IDLE);

        // Output register: a taken word frees it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Configuration writes.
        if (cfg_wr_en) begin
            priority if (cfg_index == CFG_IDX_W'(CFG_HDZ)) begin
                hdz_next = cfg_wdata[ZONE_W-1:0];
            end else if (cfg_index == CFG_IDX_W'(CFG_VDZ)) begin
                vdz_next = cfg_wdata[ZONE_W-1:0];
            end else if (cfg_index == CFG_IDX_W'(CFG_SPEED)) begin
                speed_next = cfg_wdata[15:0];
            end else if (cfg_index == CFG_IDX_W'(CFG_ZW)) begin
                zw_next = cfg_wdata[9:0];
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    done_next   = 1'b0;
                    status_next = STAT_OK;
                    state_next  = ST_OUT;
                    unique case (action_t'(s_action))
                        ACT_TICK: begin
                            if (mode_reg == MODE_TARGET) begin
                                view_x_next = follow_axis(view_x_reg, s_point_x, hdz_reg);
                                view_y_next = follow_axis(view_y_reg, s_point_y, vdz_reg);
                            end else if (mode_reg == MODE_PATH) begin
                                if (count_reg == '0) begin
                                    status_next = STAT_EMPTY;
                                    done_next   = 1'b1;
                                    mode_next   = MODE_INACTIVE;
                                end else begin
                                    travelled_next = trav_sum[32] ? 32'hFFFF_FFFF
                                                                  : trav_sum[31:0];
                                    seg_next    = '0;
                                    so_far_next = '0;
                                    ram_raddr   = '0;
                                    state_next  = (count_reg == CNT_W'(1)) ? ST_LAST
                                                                           : ST_FIRST;
                                end
                            end
                        end
                        ACT_BEGIN: begin
                            count_next     = '0;
                            travelled_next = '0;
                            if (s_continue_flag) begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = '{x: view_x_reg, y: view_y_reg,
                                               zoom: view_zoom_reg, rot: '0};
                                count_next = CNT_W'(1);
                            end
                        end
                        ACT_APPEND: begin
                            if (count_reg < CNT_W'(MAX_POINTS)) begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end else begin
                                status_next = STAT_FULL;
                            end
                        end
                        ACT_START: begin
                            travelled_next = '0;
                            mode_next      = MODE_PATH;
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end
                        end
                        ACT_MODE: begin
                            if (s_new_mode == MODE_INACTIVE || s_new_mode == MODE_TARGET
                                || s_new_mode == MODE_PATH) begin
                                mode_next = mode_t'(s_new_mode);
                            end
                        end
                        ACT_VIEW: begin
                            view_x_next    = s_point_x;
                            view_y_next    = s_point_y;
                            view_zoom_next = s_point_zoom;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_FIRST: begin
                pa_next    = ram_rdata;
                ram_raddr  = seg_reg + ADDR_W'(1);
                state_next = ST_SEG;
            end

            ST_SEG: begin
                pb_next    = ram_rdata;
                state_next = ST_MUL;
            end

            // Squares, weighted zoom difference and rotation difference, registered.
            ST_MUL: begin
                dxsq_next  = abs_diff(pa_reg.x, pb_reg.x) * abs_diff(pa_reg.x, pb_reg.x);
                dysq_next  = abs_diff(pa_reg.y, pb_reg.y) * abs_diff(pa_reg.y, pb_reg.y);
                zwdz_next  = 26'(zw_reg) * 26'((pa_reg.zoom > pb_reg.zoom)
                                               ? pa_reg.zoom - pb_reg.zoom
                                               : pb_reg.zoom - pa_reg.zoom);
                drot_next  = abs_diff(pa_reg.rot, pb_reg.rot);
                state_next = ST_SQRT_GO;
            end

            ST_SQRT_GO: begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT_WAIT;
            end

            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    len_next   = LEN_W'(sqrt_root) + LEN_W'(zwdz_reg) + LEN_W'(drot_reg);
                    state_next = ST_CMP;
                end
            end

            // Does the travelled distance end inside this segment?
            ST_CMP: begin
                if (cmp_sum > CMP_W'(travelled_reg)) begin
                    rem_next   = LEN_W'(CMP_W'(travelled_reg) - CMP_W'(so_far_reg));
                    axis_next  = AXIS_X;
                    state_next = ST_IMUL;
                end else begin
                    so_far_next = SUM_W'(cmp_sum);
                    if (CNT_W'(seg_reg) + CNT_W'(2) < count_reg) begin
                        seg_next   = seg_reg + ADDR_W'(1);
                        pa_next    = pb_reg;
                        ram_raddr  = ADDR_W'(CNT_W'(seg_reg) + CNT_W'(2));
                        state_next = ST_SEG;
                    end else begin
                        view_x_next    = pb_reg.x;
                        view_y_next    = pb_reg.y;
                        view_zoom_next = pb_reg.zoom;
                        done_next      = 1'b1;
                        mode_next      = MODE_INACTIVE;
                        state_next     = ST_OUT;
                    end
                end
            end

            // Path of one point: end at once on it.
            ST_LAST: begin
                view_x_next    = ram_rdata.x;
                view_y_next    = ram_rdata.y;
                view_zoom_next = ram_rdata.zoom;
                done_next      = 1'b1;
                mode_next      = MODE_INACTIVE;
                state_next     = ST_OUT;
            end

            ST_IMUL: begin
                neg_next   = ax_diff[POS_W];
                prod_next  = PROD_W'(ax_mag) * PROD_W'(rem_reg);
                state_next = ST_DIV_GO;
            end

            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT: begin
                if (div_done) begin
                    unique case (axis_reg)
                        AXIS_X: begin
                            view_x_next = POS_W'(ax_new);
                            axis_next   = AXIS_Y;
                            state_next  = ST_IMUL;
                        end
                        AXIS_Y: begin
                            view_y_next = POS_W'(ax_new);
                            axis_next   = AXIS_ZOOM;
                            state_next  = ST_IMUL;
                        end
                        default: begin
                            view_zoom_next = ZOOM_W'(ax_new);
                            state_next     = ST_OUT;
                        end
                    endcase
                end
            end

            // Hand the word to the output register once it is free.
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_x_next      = view_x_reg;
                    m_y_next      = view_y_reg;
                    m_zoom_next   = view_zoom_reg;
                    m_mode_next   = mode_reg;
                    m_done_next   = done_reg;
                    m_status_next = status_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_TARGET;
            view_x_reg    <= '0;
            view_y_reg    <= '0;
            view_zoom_reg <= ZOOM_ONE;
            travelled_reg <= '0;
            count_reg     <= '0;
            hdz_reg       <= HDZ_RESET;
            vdz_reg       <= VDZ_RESET;
            speed_reg     <= SPEED_RESET;
            zw_reg        <= ZW_RESET;
            done_reg      <= 1'b0;
            status_reg    <= STAT_OK;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            view_x_reg    <= view_x_next;
            view_y_reg    <= view_y_next;
            view_zoom_reg <= view_zoom_next;
            travelled_reg <= travelled_next;
            count_reg     <= count_next;
            hdz_reg       <= hdz_next;
            vdz_reg       <= vdz_next;
            speed_reg     <= speed_next;
            zw_reg        <= zw_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        seg_reg      <= seg_next;
        so_far_reg   <= so_far_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        dxsq_reg     <= dxsq_next;
        dysq_reg     <= dysq_next;
        zwdz_reg     <= zwdz_next;
        drot_reg     <= drot_next;
        len_reg      <= len_next;
        rem_reg      <= rem_next;
        axis_reg     <= axis_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        m_x_reg      <= m_x_next;
        m_y_reg      <= m_y_next;
        m_zoom_reg   <= m_zoom_next;
        m_mode_reg   <= m_mode_next;
        m_done_reg   <= m_done_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_view_x       = m_x_reg;
    assign m_view_y       = m_y_reg;
    assign m_view_zoom    = m_zoom_reg;
    assign m_current_mode = m_mode_reg;
    assign m_path_done    = m_done_reg;
    assign m_status       = m_status_reg;

endmodule

// File: sv/cpf_ram.sv
module cpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/cpf_isqrt.sv
module cpf_isqrt #(
    parameter int W = 50
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [W-1:0]     value,
    output logic             done,
    output logic [W/2-1:0]   root
);

    logic [W-1:0] v_reg;
    logic [W-1:0] r_reg;
    logic [W-1:0] bit_pos_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [W-1:0] trial;

    assign trial = r_reg + bit_pos_reg;

    // Digit-by-digit square root, one result bit per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                v_reg       <= value;
                r_reg       <= '0;
                bit_pos_reg <= W'(1) << (W - 2);
                busy_reg    <= 1'b1;
            end else if (busy_reg) begin
                if (v_reg >= trial) begin
                    v_reg <= v_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_pos_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_pos_reg <= bit_pos_reg >> 2;
                if (bit_pos_reg[0]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = r_reg[W/2-1:0];

endmodule

// File: sv/cpf_div.sv
module cpf_div #(
    parameter int NW = 51,
    parameter int DW = 27
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [DW:0]   shifted;
    logic          fits;

    assign shifted = {rem_reg[DW-1:0], num_reg[NW-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    // Restoring division; quotient bits shift into the dividend register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg <= num;
                den_reg <= den;
                rem_reg <= '0;
                cnt_reg <= CW'(NW);
            end else if (cnt_reg != '0) begin
                rem_reg <= fits ? shifted - {1'b0, den_reg} : shifted;
                num_reg <= {num_reg[NW-2:0], fits};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

// File: sim/tb_camera_path_follower.sv
module tb_camera_path_follower;
    import cpf_pkg::*;

    localparam int NPTS = 16;
    localparam int CYCLE_LIMIT = 4000000;

    // One view word as the block reports it.
    typedef struct packed {
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic [15:0]        vz;
        logic [1:0]         mode;
        logic               done;
        logic [1:0]         stat;
    } view_word_t;

    // Predicts the view controller and holds the words still awaited.
    class view_scoreboard;
        view_word_t pending[$];
        int errors;
        logic [22:0] hdz, vdz;
        logic [15:0] speed;
        logic [9:0]  zw;
        logic [1:0]  mode;
        longint      vx, vy, vz;
        longint unsigned trav;
        int          count;
        longint      px[NPTS], py[NPTS], pz[NPTS], pr[NPTS];

        function new();
            hdz = HDZ_RESET; vdz = VDZ_RESET; speed = SPEED_RESET; zw = ZW_RESET;
            mode = MODE_TARGET; vx = 0; vy = 0; vz = 256; trav = 0; count = 0;
            errors = 0;
        endfunction

        function void write_reg(int idx, logic [22:0] val);
            case (idx)
                CFG_HDZ:   hdz = val;
                CFG_VDZ:   vdz = val[22:0];
                CFG_SPEED: speed = val[15:0];
                CFG_ZW:    zw = val[9:0];
                default: ;
            endcase
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint unsigned mag(longint a, longint b);
            return (a > b) ? a - b : b - a;
        endfunction

        function longint follow(longint v, longint t, longint z);
            longint r;
            r = v;
            if (t - v > z) r = t - z;
            else if (t - v < -z) r = t + z;
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
            return r;
        endfunction

        // Walks the polyline; returns 1 when the end is reached.
        function bit walk();
            longint unsigned sofar, len, dx, dy, rem;
            sofar = 0;
            for (int i = 0; i + 1 < count; i++) begin
                dx = mag(px[i], px[i+1]);
                dy = mag(py[i], py[i+1]);
                len = root(dx*dx + dy*dy) + zw * mag(pz[i], pz[i+1]) + mag(pr[i], pr[i+1]);
                if (sofar + len > trav) begin
                    rem = trav - sofar;
                    vx = px[i] + ((px[i+1] - px[i]) * longint'(rem)) / longint'(len);
                    vy = py[i] + ((py[i+1] - py[i]) * longint'(rem)) / longint'(len);
                    vz = pz[i] + ((pz[i+1] - pz[i]) * longint'(rem)) / longint'(len);
                    return 0;
                end
                sofar += len;
            end
            vx = px[count-1]; vy = py[count-1]; vz = pz[count-1];
            return 1;
        endfunction

        function void note_input(logic [2:0] act, logic signed [23:0] ix, logic signed [23:0] iy,
                                 logic [15:0] iz, logic signed [23:0] ir, logic [15:0] tt,
                                 logic cf, logic [1:0] nm);
            view_word_t w;
            longint unsigned t;
            w.done = 0;
            w.stat = STAT_OK;
            case (act)
                ACT_TICK: begin
                    if (mode == MODE_TARGET) begin
                        vx = follow(vx, ix, hdz);
                        vy = follow(vy, iy, vdz);
                    end else if (mode == MODE_PATH) begin
                        if (count == 0) begin
                            w.stat = STAT_EMPTY; w.done = 1; mode = MODE_INACTIVE;
                        end else begin
                            t = trav + ((longint'(tt) * speed) >> 8);
                            trav = (t > 64'hFFFFFFFF) ? 64'hFFFFFFFF : t;
                            if (walk()) begin
                                w.done = 1; mode = MODE_INACTIVE;
                            end
                        end
                    end
                end
                ACT_BEGIN: begin
                    count = 0; trav = 0;
                    if (cf) begin
                        px[0] = vx; py[0] = vy; pz[0] = vz; pr[0] = 0; count = 1;
                    end
                end
                ACT_APPEND: begin
                    if (count < NPTS) begin
                        px[count] = ix; py[count] = iy; pz[count] = iz; pr[count] = ir;
                        count++;
                    end else begin
                        w.stat = STAT_FULL;
                    end
                end
                ACT_START: begin
                    trav = 0; mode = MODE_PATH;
                    if (count == 0) w.stat = STAT_EMPTY;
                end
                ACT_MODE: if (nm <= 2) mode = nm;
                ACT_VIEW: begin
                    vx = ix; vy = iy; vz = iz;
                end
                default: ;
            endcase
            w.vx = vx[23:0]; w.vy = vy[23:0]; w.vz = vz[15:0]; w.mode = mode;
            pending = {pending, w};
        endfunction

        function void check_word(view_word_t got);
            view_word_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.vx !== exp.vx) begin
                $display("%0t: view_x expected %0d got %0d", $time, exp.vx, got.vx); errors++;
            end
            if (got.vy !== exp.vy) begin
                $display("%0t: view_y expected %0d got %0d", $time, exp.vy, got.vy); errors++;
            end
            if (got.vz !== exp.vz) begin
                $display("%0t: view_zoom expected %0d got %0d", $time, exp.vz, got.vz); errors++;
            end
            if (got.mode !== exp.mode) begin
                $display("%0t: mode expected %0d got %0d", $time, exp.mode, got.mode); errors++;
            end
            if (got.done !== exp.done) begin
                $display("%0t: path_done expected %0d got %0d", $time, exp.done, got.done);
                errors++;
            end
            if (got.stat !== exp.stat) begin
                $display("%0t: status expected %0d got %0d", $time, exp.stat, got.stat);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [2:0] cfg_index = 0;
    logic [22:0] cfg_wdata = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [2:0] s_action = 0;
    logic signed [23:0] s_point_x = 0, s_point_y = 0, s_point_rotation = 0;
    logic [15:0] s_point_zoom = 0, s_tick_time = 0;
    logic s_continue_flag = 0;
    logic [1:0] s_new_mode = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [23:0] m_view_x, m_view_y;
    logic [15:0] m_view_zoom;
    logic [1:0] m_current_mode, m_status;
    logic m_path_done;

    view_scoreboard sb;
    bit calm = 0;
    int cycles = 0;

    camera_path_follower dut (.*);

    always #5 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random back-pressure bursts, checking each accepted word.
    initial begin
        int n;
        sb = new();
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_word({m_view_x, m_view_y, m_view_zoom, m_current_mode,
                               m_path_done, m_status});
            if (n > 0) begin
                n--;
                m_ready <= 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 13) - 1;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    // Writes one register; the enable stays high until cfg_release.
    task automatic write_cfg(int idx, logic [22:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic cfg_release();
        cfg_wr_en <= 0;
    endtask

    // Waits until every expected word is back, then a settling gap.
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Offers one word, holding it until accepted, with an optional idle burst first.
    task automatic send(logic [2:0] act, logic signed [23:0] ix, logic signed [23:0] iy,
                        logic [15:0] iz, logic signed [23:0] ir, logic [15:0] tt,
                        logic cf, logic [1:0] nm);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1;
        s_action <= act; s_point_x <= ix; s_point_y <= iy; s_point_zoom <= iz;
        s_point_rotation <= ir; s_tick_time <= tt; s_continue_flag <= cf; s_new_mode <= nm;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(act, ix, iy, iz, ir, tt, cf, nm);
    endtask

    task automatic idle_in();
        s_valid <= 0;
        @(posedge aclk);
    endtask

    // One random path point, with x, y and rotation drawn within plus or minus span.
    task automatic rand_append(int span);
        send(ACT_APPEND, $urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span,
             $urandom_range(0, 1023), $urandom_range(0, 2*span) - span, $urandom, 0, 0);
    endtask

    task automatic rand_noise();
        logic [2:0] a;
        a = $urandom_range(0, 7);
        if (a == ACT_MODE) a = $urandom_range(0, 1) ? ACT_TICK : ACT_MODE;
        send(a, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial begin
        int span;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: follow target at the extremes, special paths, then mode, view, unused actions.
        send(ACT_TICK, 24'sh7FFFFF, 24'sh800000, 0, 0, 0, 0, 0);
        send(ACT_TICK, 24'sh800000, 24'sh7FFFFF, 0, 0, 0, 0, 0);
        send(ACT_TICK, 100, -100, 0, 0, 0, 0, 0);
        send(ACT_START, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_TICK, 0, 0, 0, 0, 16'hFFFF, 0, 0);
        send(ACT_BEGIN, 0, 0, 0, 0, 0, 1, 0);
        send(ACT_START, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_TICK, 0, 0, 0, 0, 100, 0, 0);
        send(ACT_BEGIN, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++)
            send(ACT_APPEND, (i & 1) ? 24'sh7FFFFF : 24'sh800000, i * 5000,
                 (i & 1) ? 16'hFFFF : 0, (i & 2) ? 24'sh7FFFFF : 24'sh800000, 0, 0, 0);
        send(ACT_START, 0, 0, 0, 0, 0, 0, 0);
        send(ACT_TICK, 0, 0, 0, 0, 16'hFFFF, 0, 0);
        send(ACT_MODE, 0, 0, 0, 0, 0, 0, 3);
        send(ACT_MODE, 0, 0, 0, 0, 0, 0, MODE_INACTIVE);
        send(ACT_TICK, 5, 5, 0, 0, 5, 0, 0);
        send(ACT_VIEW, 24'sh7FFFFF, 24'sh800000, 16'hFFFF, 0, 0, 0, 0);
        send(6, 0, 0, 0, 0, 0, 0, 0);
        send(7, 24'shFFFFFF, 24'shFFFFFF, 16'hFFFF, 24'shFFFFFF, 16'hFFFF, 1, 3);
        send(ACT_MODE, 0, 0, 0, 0, 0, 0, MODE_TARGET);
        idle_in();
        drain();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_cfg(CFG_HDZ, 0); write_cfg(CFG_VDZ, 23'h7FFFFF);
                    write_cfg(CFG_SPEED, 16'hFFFF); write_cfg(CFG_ZW, 0);
                end
                1: begin
                    write_cfg(CFG_HDZ, 23'h7FFFFF); write_cfg(CFG_VDZ, 0);
                    write_cfg(CFG_SPEED, 0); write_cfg(CFG_ZW, 10'h3FF);
                end
                2: begin
                    write_cfg(4, 23'h7FFFFF); write_cfg(CFG_SPEED, 16'd50);
                    write_cfg(CFG_ZW, 10'd100);
                end
                default: begin
                    write_cfg(CFG_HDZ, $urandom); write_cfg(CFG_VDZ, $urandom);
                    write_cfg(CFG_SPEED, $urandom_range(0, 3) == 0 ? $urandom
                                                                    : $urandom_range(1, 4000));
                    write_cfg(CFG_ZW, $urandom);
                end
            endcase
            cfg_release();
            if (ph == 7) calm = 1;
            for (int k = 0; k < 8; k++) begin
                // A path run: begin, random points (at times more than fit), start, then random ticks.
                span = ($urandom_range(0, 4) == 0) ? 8388607 : $urandom_range(1, 40000);
                send(ACT_BEGIN, 0, 0, 0, 0, 0, $urandom, 0);
                repeat ($urandom_range(0, 5) == 0 ? 17 : $urandom_range(0, 5))
                    rand_append(span);
                send(ACT_START, 0, 0, 0, 0, 0, 0, 0);
                repeat ($urandom_range(2, 10))
                    send(ACT_TICK, $urandom, $urandom, 0, 0, $urandom, 0, 0);
                // Follow-target run, then a little noise.
                send(ACT_MODE, 0, 0, 0, 0, 0, 0, MODE_TARGET);
                repeat ($urandom_range(1, 4))
                    send(ACT_TICK, $urandom, $urandom, 0, 0, 0, 0, 0);
                repeat ($urandom_range(0, 2)) rand_noise();
            end
            idle_in();
            drain();
        end

        drain();
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
